// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker of this block.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hdl/wfm_pkg.sv =====
// ----------------------------------------------------------------------------
// Windowed frequency meter package
// Sizes, constants and the controller state type of the frequency meter.
// ----------------------------------------------------------------------------
package wfm_pkg;

	localparam int WINDOW = 100;
	localparam int TIME_W = 32;
	localparam int FREQ_W = 28;
	localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = TIME_W + $clog2(WINDOW);
	localparam int NUM_W  = FREQ_W + CNT_W;
	localparam int BIT_W  = $clog2(NUM_W + 1);

	localparam logic [FREQ_W-1:0] FREQ_NUM_Q8 = FREQ_W'(256000000);
	localparam logic [FREQ_W-1:0] FREQ_MAX_Q8 = FREQ_W'(256000000);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_ADD,
		ST_CHECK,
		ST_DIV,
		ST_DONE
	} wfm_state_t;

endpackage

// ===== hdl/windowed_frequency_meter_core.sv =====
// ----------------------------------------------------------------------------
// Windowed frequency meter core
// Averages the intervals between timestamped events over a sliding window and
// returns the mean event rate in Hz with eight fractional bits.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the input channel (in_valid, in_ready, time_us) is one
// event. Each event yields exactly one transfer on the output channel
// (out_valid, out_ready, freq_q8, valid_avg), in order.
// The first event after reset only records its time and returns zero.
// A later event writes its interval into a ring memory, updates the window
// sum in ST_SUB and ST_ADD, and then runs a restoring divider in ST_DIV that
// produces one quotient bit per cycle. The result is loaded into the output
// register from ST_DONE, after ST_CHECK and the divider, and the next event
// is taken once the core is back in ST_IDLE. The first event skips ST_SUB
// and ST_ADD; it and any event whose average is undefined skip the divider
// and go from ST_CHECK straight to ST_DONE.
// The output register holds a finished result while the receiver stalls;
// the following event is still taken and worked on, and its result waits
// until the output register is free.
// Reset clears the window and all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module windowed_frequency_meter_core
	import wfm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [TIME_W-1:0] time_us,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [FREQ_W-1:0] freq_q8,
	output logic              valid_avg
);

	wfm_state_t        state_q;
	wfm_state_t        state_next;

	logic [TIME_W-1:0] last_q;
	logic              started_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [BIT_W-1:0]  bit_q;
	logic              ok_q;

	logic [TIME_W-1:0] iv_q;
	logic [TIME_W-1:0] rd_q;
	logic [NUM_W-1:0]  num_q;
	logic [SUM_W-1:0]  rem_q;

	logic              out_valid_q;
	logic [FREQ_W-1:0] freq_q;
	logic              avg_q;

	logic [TIME_W-1:0] ring [WINDOW];

	logic              in_xfer;
	logic              ring_we;
	logic              out_load;
	logic              full;
	logic              div_ok;
	logic [SUM_W:0]    rem_shift;
	logic [SUM_W+1:0]  diff;
	logic              borrow;

	assign in_xfer   = in_valid && in_ready;
	assign full      = (count_q == CNT_W'(WINDOW));
	assign div_ok    = (count_q >= CNT_W'(2)) && (sum_q != '0);
	assign rem_shift = {rem_q, num_q[NUM_W-1]};
	assign diff      = {1'b0, rem_shift} - {2'b00, sum_q};
	assign borrow    = diff[SUM_W+1];

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = started_q ? ST_SUB : ST_CHECK;
				end
			end
			ST_SUB:   state_next = ST_ADD;
			ST_ADD:   state_next = ST_CHECK;
			ST_CHECK: state_next = div_ok ? ST_DIV : ST_DONE;
			ST_DIV: begin
				if (bit_q == BIT_W'(1)) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_next = ST_IDLE;
				end
			end
			default:  state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		ring_we  = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_SUB:  ring_we  = 1'b1;
			ST_DONE: out_load = !out_valid_q || out_ready;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			last_q    <= '0;
			started_q <= 1'b0;
			slot_q    <= '0;
			count_q   <= '0;
			sum_q     <= '0;
			bit_q     <= '0;
			ok_q      <= 1'b0;
		end else begin
			state_q <= state_next;
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						last_q    <= time_us;
						started_q <= 1'b1;
					end
				end
				ST_SUB: begin
					if (full) begin
						sum_q <= sum_q - SUM_W'(rd_q);
					end
				end
				ST_ADD: begin
					sum_q  <= sum_q + SUM_W'(iv_q);
					slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
					if (!full) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				ST_CHECK: begin
					bit_q <= BIT_W'(NUM_W);
					ok_q  <= div_ok;
				end
				ST_DIV: begin
					bit_q <= bit_q - BIT_W'(1);
				end
				default: begin
					ok_q <= ok_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					iv_q <= time_us - last_q;
				end
			end
			ST_CHECK: begin
				num_q <= NUM_W'(FREQ_NUM_Q8) * NUM_W'(count_q);
				rem_q <= '0;
			end
			ST_DIV: begin
				rem_q <= borrow ? rem_shift[SUM_W-1:0] : diff[SUM_W-1:0];
				num_q <= {num_q[NUM_W-2:0], !borrow};
			end
			default: begin
				num_q <= num_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring[slot_q] <= iv_q;
		end
		if (in_xfer) begin
			rd_q <= ring[slot_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (!ok_q) begin
				freq_q <= '0;
			end else if (num_q > NUM_W'(FREQ_MAX_Q8)) begin
				freq_q <= FREQ_MAX_Q8;
			end else begin
				freq_q <= num_q[FREQ_W-1:0];
			end
			avg_q <= ok_q;
		end
	end

	assign out_valid = out_valid_q;
	assign freq_q8   = freq_q;
	assign valid_avg = avg_q;

endmodule

// ===== hdl/wfm_checker.sv =====
// ----------------------------------------------------------------------------
// Windowed frequency meter checker
// Port-level assertions on the frequency meter core, attached by a bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wfm_checker
	import wfm_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic [TIME_W-1:0] time_us,
	input logic              out_valid,
	input logic              out_ready,
	input logic [FREQ_W-1:0] freq_q8,
	input logic              valid_avg
);

	logic unused_time;

	assign unused_time = ^time_us;

	// A stalled result holds its value.
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(freq_q8) && $stable(valid_avg))
	// An undefined average is reported as zero.
	`ASSERT_SAME(a_zero_when_invalid, out_valid && !valid_avg, freq_q8 == '0)
	// The frequency never exceeds its saturation limit.
	`ASSERT_SAME(a_freq_limit, out_valid, freq_q8 <= FREQ_MAX_Q8)
	// After an input transfer the core is busy in the following cycle.
	`ASSERT_NEXT(a_busy_after_xfer, in_valid && in_ready, !in_ready)

endmodule

bind windowed_frequency_meter_core wfm_checker u_wfm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.time_us   (time_us),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.freq_q8   (freq_q8),
	.valid_avg (valid_avg)
);
